@@ rtl/core/bta_pkg.sv @@
package bta_pkg;

  // default geometry
  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_BLOCK_BYTES   = 64;
  localparam int DEF_POOLS         = 2;

  // request and response field widths
  localparam int CMD_W    = 2;
  localparam int POOL_W   = 1;
  localparam int SIZE_W   = 17;
  localparam int OFFSET_W = 17;
  localparam int REGION_W = 16;
  localparam int USAGE_W  = 10;

  // usage scale and divider quotient width
  localparam int PERMILLE = 1000;
  localparam int QUO_W    = SIZE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_USAGE,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_RANGE,
    ST_ZERO
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_POST,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WAIT,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/bta_req_if.sv @@
interface bta_req_if import bta_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [POOL_W-1:0]   pool;
  logic [SIZE_W-1:0]   size;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, command, pool, size, offset, input ready);
  modport sink (input valid, command, pool, size, offset, output ready);
endinterface

@@ rtl/core/bta_rsp_if.sv @@
interface bta_rsp_if import bta_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [REGION_W-1:0] region_offset;
  logic [USAGE_W-1:0]  usage_permille;

  modport source (output valid, status, region_offset, usage_permille, input ready);
  modport sink (input valid, status, region_offset, usage_permille, output ready);
endinterface

@@ rtl/core/block_table_allocator_core.sv @@
// alloc: accept, multiply, setup, scan of the table, writes of the run, resp
// free: accept, multiply, setup, fetch of the count, one write per cleared entry, resp
// usage: accept, scan of the table, resp; throughput one request at a time
// the table memory has one read and one write port; the scan reads one entry per cycle
// clear and reset both sweep the whole table, all POOLS * 2**clog2(TABLE_ENTRIES) entries,
// during which no request is taken; the response register frees the next request early
module block_table_allocator_core import bta_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES,
  parameter int POOLS         = DEF_POOLS
) (
  input logic       clk,
  input logic       rst,
  bta_req_if.sink   req,
  bta_rsp_if.source rsp
);

  localparam int EW         = $clog2(TABLE_ENTRIES);
  localparam int CW         = $clog2(TABLE_ENTRIES + 1);
  localparam int PW         = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int MEM_DEPTH  = POOLS << EW;
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int POOL_BYTES = TABLE_ENTRIES * BLOCK_BYTES;
  localparam int DX_W       = ((SIZE_W > OFFSET_W) ? SIZE_W : OFFSET_W) + 1;
  localparam int BL         = $clog2(BLOCK_BYTES);
  localparam int SH         = DX_W + BL;
  localparam int RC_W       = DX_W + 1;
  localparam int PR_W       = DX_W + RC_W;

  // reciprocal of the block size, exact for every dividend below 2**DX_W
  localparam longint RECIP_L =
    ((longint'(1) << SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);

  localparam logic [RC_W-1:0]    RECIP    = RC_W'(RECIP_L);
  localparam logic [DX_W-1:0]    ROUND_UP = DX_W'(BLOCK_BYTES - 1);
  localparam logic [USAGE_W-1:0] U_Q      = USAGE_W'(PERMILLE / TABLE_ENTRIES);
  localparam logic [CW:0]        U_R      = (CW + 1)'(PERMILLE % TABLE_ENTRIES);
  localparam logic [CW:0]        T_WRAP   = (CW + 1)'(TABLE_ENTRIES);
  localparam logic [CW-1:0]      T_CNT    = CW'(TABLE_ENTRIES);
  localparam logic [EW-1:0]      T_TOP    = EW'(TABLE_ENTRIES - 1);

  // table address of one entry in one pool
  function automatic logic [AW-1:0] ent_addr(input logic [PW-1:0] p, input logic [EW-1:0] e);
    ent_addr = AW'({p, e});
  endfunction

  state_t state, state_next;
  cmd_t   cmd_r, cmd_r_next;
  logic [PW-1:0]       pool_r, pool_r_next;
  logic [DX_W-1:0]     dvd, dvd_next;
  logic [QUO_W-1:0]    quo, quo_next;
  logic [CW-1:0]       need, need_next;
  logic [CW-1:0]       run, run_next;
  logic [CW-1:0]       left, left_next;
  logic [EW-1:0]       ptr, ptr_next;
  logic                pend, pend_next;
  logic [EW-1:0]       pend_e, pend_e_next;
  logic [USAGE_W-1:0]  acc_quo, acc_quo_next;
  logic [CW:0]         acc_rem, acc_rem_next;
  logic [EW-1:0]       wptr, wptr_next;
  logic [CW-1:0]       wleft, wleft_next;
  logic [CW-1:0]       wval, wval_next;
  logic [EW-1:0]       run_e, run_e_next;
  logic [AW-1:0]       clr_ptr, clr_ptr_next;
  logic                clr_resp, clr_resp_next;
  status_t             res_status, res_status_next;
  logic [REGION_W-1:0] res_offset, res_offset_next;
  logic [USAGE_W-1:0]  res_usage, res_usage_next;
  logic                out_valid, out_valid_next;
  status_t             out_status, out_status_next;
  logic [REGION_W-1:0] out_offset, out_offset_next;
  logic [USAGE_W-1:0]  out_usage, out_usage_next;

  // table memory
  logic [CW-1:0] mem [MEM_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata, mem_rdata;

  // shared helper terms
  logic              pool_bad, off_bad, size_zero;
  logic [PR_W-1:0]   prod;
  logic [CW-1:0]     run_inc;
  logic              match;
  logic              need_big;
  logic [CW-1:0]     lim;
  logic [CW:0]       acc_sum;
  logic              acc_wrap;
  logic [REGION_W-1:0] offset_calc;

  assign pool_bad    = 32'(req.pool) >= 32'(POOLS);
  assign off_bad     = 32'(req.offset) >= 32'(POOL_BYTES);
  assign size_zero   = req.size == '0;
  assign prod        = PR_W'(dvd) * PR_W'(RECIP);
  assign run_inc     = (mem_rdata == '0) ? run + 1'b1 : '0;
  assign match       = run_inc == need;
  assign need_big    = 32'(quo) > 32'(TABLE_ENTRIES);
  assign lim         = T_CNT - CW'(wptr);
  assign acc_sum     = acc_rem + U_R;
  assign acc_wrap    = acc_sum >= T_WRAP;
  assign offset_calc = REGION_W'(32'(run_e) * 32'(BLOCK_BYTES));

  // port drive
  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.region_offset  = out_offset;
  assign rsp.usage_permille = out_usage;

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_ptr == AW'(MEM_DEPTH - 1)) state_next = clr_resp ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_CLEAR) state_next = S_CLEAR;
          else if (pool_bad) state_next = S_RESP;
          else if (req.command == CMD_ALLOC) state_next = size_zero ? S_RESP : S_DIV;
          else if (req.command == CMD_FREE) state_next = off_bad ? S_RESP : S_DIV;
          else state_next = S_SCAN;
        end
      end
      S_DIV: state_next = S_POST;
      S_POST: begin
        if (cmd_r == CMD_ALLOC) state_next = need_big ? S_RESP : S_SCAN;
        else state_next = S_FREE_RD;
      end
      S_SCAN: begin
        if (pend && cmd_r == CMD_ALLOC && match) state_next = S_WRITE;
        else if (!pend && left == '0) state_next = S_RESP;
      end
      S_FREE_RD:   state_next = S_FREE_WAIT;
      S_FREE_WAIT: state_next = S_WRITE;
      S_WRITE: begin
        if (wleft == '0) state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_r_next      = cmd_r;
    pool_r_next     = pool_r;
    dvd_next        = dvd;
    quo_next        = quo;
    need_next       = need;
    run_next        = run;
    left_next       = left;
    ptr_next        = ptr;
    pend_next       = pend;
    pend_e_next     = pend_e;
    acc_quo_next    = acc_quo;
    acc_rem_next    = acc_rem;
    wptr_next       = wptr;
    wleft_next      = wleft;
    wval_next       = wval;
    run_e_next      = run_e;
    clr_ptr_next    = clr_ptr;
    clr_resp_next   = clr_resp;
    res_status_next = res_status;
    res_offset_next = res_offset;
    res_usage_next  = res_usage;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_offset_next = out_offset;
    out_usage_next  = out_usage;
    mem_we          = 1'b0;
    mem_waddr       = clr_ptr;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = ent_addr(pool_r, ptr);

    case (state)
      // sweep every table entry to zero
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_ptr;
        mem_wdata       = '0;
        clr_ptr_next    = clr_ptr + 1'b1;
        res_status_next = ST_OK;
        res_offset_next = '0;
        res_usage_next  = '0;
      end

      // take a request and set up its first step
      S_IDLE: begin
        if (req.valid) begin
          cmd_r_next      = req.command;
          pool_r_next     = PW'(req.pool);
          res_status_next = ST_OK;
          res_offset_next = '0;
          res_usage_next  = '0;
          if (req.command == CMD_CLEAR) begin
            clr_ptr_next  = '0;
            clr_resp_next = 1'b1;
          end else if (pool_bad) begin
            res_status_next = ST_RANGE;
          end else if (req.command == CMD_ALLOC) begin
            if (size_zero) begin
              res_status_next = ST_ZERO;
            end else begin
              // round up to whole blocks before the divide
              dvd_next = DX_W'(req.size) + ROUND_UP;
            end
          end else if (req.command == CMD_FREE) begin
            if (off_bad) begin
              res_status_next = ST_RANGE;
            end else begin
              dvd_next = DX_W'(req.offset);
            end
          end else begin
            left_next    = T_CNT;
            ptr_next     = T_TOP;
            pend_next    = 1'b0;
            acc_quo_next = '0;
            acc_rem_next = '0;
          end
        end
      end

      // divide by the block size through the reciprocal
      S_DIV: begin
        quo_next = QUO_W'(prod >> SH);
      end

      // act on the quotient
      S_POST: begin
        if (cmd_r == CMD_ALLOC) begin
          if (need_big) begin
            res_status_next = ST_NOSPACE;
          end else begin
            need_next = CW'(quo);
            left_next = T_CNT;
            ptr_next  = T_TOP;
            run_next  = '0;
            pend_next = 1'b0;
          end
        end else begin
          wptr_next = EW'(quo);
        end
      end

      // read entries from the top down, one per cycle, check the one read last cycle
      S_SCAN: begin
        if (left != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = ent_addr(pool_r, ptr);
          ptr_next    = ptr - 1'b1;
          left_next   = left - 1'b1;
          pend_next   = 1'b1;
          pend_e_next = ptr;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (cmd_r == CMD_ALLOC) begin
            run_next = run_inc;
            if (match) begin
              wptr_next  = pend_e;
              run_e_next = pend_e;
              wleft_next = need;
              wval_next  = need;
            end
          end else if (mem_rdata != '0) begin
            // permille kept as quotient and remainder of the table size
            acc_rem_next = acc_wrap ? acc_sum - T_WRAP : acc_sum;
            acc_quo_next = acc_quo + U_Q + USAGE_W'(acc_wrap);
          end
        end else if (left == '0) begin
          if (cmd_r == CMD_ALLOC) begin
            res_status_next = ST_NOSPACE;
          end else begin
            res_usage_next = acc_quo;
          end
        end
      end

      // fetch the run length stored at the freed block
      S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ent_addr(pool_r, wptr);
      end

      // clip the count at the table end
      S_FREE_WAIT: begin
        wleft_next = (mem_rdata < lim) ? mem_rdata : lim;
        wval_next  = '0;
      end

      // stamp or clear the run, one entry per cycle
      S_WRITE: begin
        if (wleft == '0) begin
          res_status_next = ST_OK;
          res_offset_next = (cmd_r == CMD_ALLOC) ? offset_calc : '0;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = ent_addr(pool_r, wptr);
          mem_wdata  = wval;
          wptr_next  = wptr + 1'b1;
          wleft_next = wleft - 1'b1;
        end
      end

      // hand the result to the response register
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_offset_next = res_offset;
          out_usage_next  = res_usage;
        end
      end

      default: begin
        out_valid_next = out_valid && !rsp.ready;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      clr_resp  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_ptr   <= clr_ptr_next;
      clr_resp  <= clr_resp_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_r_next;
    pool_r     <= pool_r_next;
    dvd        <= dvd_next;
    quo        <= quo_next;
    need       <= need_next;
    run        <= run_next;
    left       <= left_next;
    ptr        <= ptr_next;
    pend       <= pend_next;
    pend_e     <= pend_e_next;
    acc_quo    <= acc_quo_next;
    acc_rem    <= acc_rem_next;
    wptr       <= wptr_next;
    wleft      <= wleft_next;
    wval       <= wval_next;
    run_e      <= run_e_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    res_usage  <= res_usage_next;
    out_status <= out_status_next;
    out_offset <= out_offset_next;
    out_usage  <= out_usage_next;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bta_pkg::*;

  localparam int ENTRIES      = DEF_TABLE_ENTRIES;
  localparam int BLK          = DEF_BLOCK_BYTES;
  localparam int NPOOL        = DEF_POOLS;
  localparam int POOL_BYTES   = ENTRIES * BLK;
  localparam int RANDOM_ITEMS = 265;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 64;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    cmd_t                command;
    logic [POOL_W-1:0]   pool;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] offset;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [REGION_W-1:0] region;
    logic [USAGE_W-1:0]  usage;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bta_req_if req_ch ();
  bta_rsp_if rsp_ch ();

  block_table_allocator_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  request_t                   req_backlog[$];
  answer_t                    answers_due[$];
  // {pool, offset} of runs handed out and not yet freed on purpose
  logic [POOL_W+OFFSET_W-1:0] live_runs[$];
  int unsigned                run_len[NPOOL][ENTRIES];
  int                         errors;
  int                         cycles;
  int                         cmd_seen[4];
  int                         status_seen[4];

  request_t in_flight;
  int       req_gap;
  bit       req_quiet;
  int       rsp_stall;
  bit       rsp_quiet;

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int pick_idle(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // expected answer for one accepted request, updating the shadow tables
  function automatic answer_t predict_answer(request_t r);
    answer_t     a;
    int unsigned need, run, e, idx, cnt, used;
    bit          found;
    a.status = ST_OK;
    a.region = '0;
    a.usage  = '0;
    case (r.command)
      CMD_CLEAR: begin
        for (int p = 0; p < NPOOL; p++)
          for (int k = 0; k < ENTRIES; k++) run_len[p][k] = 0;
        live_runs.delete();
      end
      CMD_ALLOC: begin
        if (r.size == 0) begin
          a.status = ST_ZERO;
        end else begin
          need = (r.size + BLK - 1) / BLK;
          a.status = ST_NOSPACE;
          if (need <= ENTRIES) begin
            // first fit, scanning from the top entry down
            run = 0;
            found = 1'b0;
            for (int k = ENTRIES; k > 0 && !found; k--) begin
              e = k - 1;
              run = (run_len[r.pool][e] != 0) ? 0 : run + 1;
              if (run == need) begin
                found = 1'b1;
                for (int j = 0; j < need; j++) run_len[r.pool][e + j] = need;
                a.status = ST_OK;
                a.region = REGION_W'(e * BLK);
                live_runs.push_back({r.pool, OFFSET_W'(e * BLK)});
              end
            end
          end
        end
      end
      CMD_FREE: begin
        if (r.offset >= POOL_BYTES) begin
          a.status = ST_RANGE;
        end else begin
          idx = r.offset / BLK;
          cnt = run_len[r.pool][idx];
          // clearing stops at the table end
          if (cnt > ENTRIES - idx) cnt = ENTRIES - idx;
          for (int j = 0; j < cnt; j++) run_len[r.pool][idx + j] = 0;
        end
      end
      default: begin
        used = 0;
        for (int k = 0; k < ENTRIES; k++)
          if (run_len[r.pool][k] != 0) used++;
        a.usage = USAGE_W'((used * PERMILLE) / ENTRIES);
      end
    endcase
    cmd_seen[r.command]++;
    status_seen[a.status]++;
    return a;
  endfunction

  task automatic queue_req(cmd_t c, int p, int s, int o);
    request_t r;
    r.command = c;
    r.pool    = POOL_W'(p);
    r.size    = SIZE_W'(s);
    r.offset  = OFFSET_W'(o);
    req_backlog.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) answers_due.push_back(predict_answer(in_flight));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_flight = req_backlog.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.command <= in_flight.command;
          req_ch.pool    <= in_flight.pool;
          req_ch.size    <= in_flight.size;
          req_ch.offset  <= in_flight.offset;
          if ($urandom_range(0, 24) == 0) req_quiet = !req_quiet;
          req_gap = pick_idle(req_quiet);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and backpressure
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: response with none pending: status %0d region %0d usage %0d",
                   $time, rsp_ch.status, rsp_ch.region_offset, rsp_ch.usage_permille);
        end else begin
          want = answers_due.pop_front();
          if (rsp_ch.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_ch.status);
          end
          if (rsp_ch.region_offset !== want.region) begin
            errors++;
            $display("%0t: region_offset expected %0d actual %0d", $time, want.region,
                     rsp_ch.region_offset);
          end
          if (rsp_ch.usage_permille !== want.usage) begin
            errors++;
            $display("%0t: usage_permille expected %0d actual %0d", $time, want.usage,
                     rsp_ch.usage_permille);
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
        if ($urandom_range(0, 3) == 0) rsp_stall = pick_idle(rsp_quiet);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests queued, %0d answers pending", $time,
               req_backlog.size(), answers_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    request_t                   r;
    int                         kind;
    int                         pick;
    logic [POOL_W+OFFSET_W-1:0] run_ref;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_ALLOC;
    req_ch.pool    = '0;
    req_ch.size    = '0;
    req_ch.offset  = '0;
    rsp_ch.ready   = 1'b0;
    errors    = 0;
    cycles    = 0;
    req_quiet = 1'b0;
    rsp_quiet = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cmd_seen[i]    = 0;
      status_seen[i] = 0;
    end
    for (int p = 0; p < NPOOL; p++)
      for (int k = 0; k < ENTRIES; k++) run_len[p][k] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of the fields and the corner cases
    queue_req(CMD_USAGE, 0, 0, 0);
    queue_req(CMD_ALLOC, 0, 0, 131071);                 // zero size
    queue_req(CMD_ALLOC, 0, 1, 0);                      // one byte, top block
    queue_req(CMD_ALLOC, 0, BLK, 0);                    // exactly one block
    queue_req(CMD_ALLOC, 0, BLK + 1, 0);                // rounds up to two
    queue_req(CMD_ALLOC, 0, 131071, 0);                 // far past the pool
    queue_req(CMD_ALLOC, 0, POOL_BYTES + 1, 0);         // one block past the pool
    queue_req(CMD_FREE, 0, 131071, POOL_BYTES);         // offset just out of pool
    queue_req(CMD_FREE, 0, 0, 131071);                  // offset all ones
    queue_req(CMD_FREE, 0, 0, 0);                       // free of a free block
    queue_req(CMD_FREE, 0, 0, (ENTRIES - 3) * BLK);     // inside the two-block run
    queue_req(CMD_USAGE, 0, 0, 0);
    queue_req(CMD_ALLOC, 1, 4 * BLK, 0);                // four blocks at the top
    queue_req(CMD_FREE, 1, 0, (ENTRIES - 2) * BLK + 5); // count clipped at table end
    queue_req(CMD_USAGE, 1, 0, 0);
    queue_req(CMD_ALLOC, 1, POOL_BYTES, 0);             // whole pool, no room left
    queue_req(CMD_FREE, 1, 0, (ENTRIES - 4) * BLK);
    queue_req(CMD_ALLOC, 1, POOL_BYTES, 0);             // whole pool fits
    queue_req(CMD_USAGE, 1, 0, 0);
    queue_req(CMD_ALLOC, 1, 1, 0);                      // full pool
    queue_req(CMD_FREE, 1, 0, 0);
    queue_req(CMD_USAGE, 1, 0, 0);
    queue_req(CMD_ALLOC, 1, 3 * BLK - 1, 0);
    queue_req(CMD_CLEAR, 1, 131071, 131071);
    queue_req(CMD_USAGE, 0, 0, 0);

    // random: mostly allocs and frees of live runs, some stray offsets
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      while (req_backlog.size() >= 2) @(posedge clk);
      kind     = $urandom_range(0, 99);
      r.pool   = POOL_W'($urandom_range(0, NPOOL - 1));
      r.size   = SIZE_W'($urandom);
      r.offset = OFFSET_W'($urandom);
      if (kind < 48) begin
        r.command = CMD_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 70) r.size = SIZE_W'($urandom_range(1, 8 * BLK));
        else if (pick < 90) r.size = SIZE_W'($urandom_range(1, 64 * BLK));
        else if (pick < 97) r.size = SIZE_W'($urandom_range(64 * BLK + 1, POOL_BYTES / 2));
        else r.size = SIZE_W'($urandom_range(0, 131071));
      end else if (kind < 80) begin
        r.command = CMD_FREE;
        if (live_runs.size() > 0 && $urandom_range(0, 9) < 8) begin
          pick    = $urandom_range(0, live_runs.size() - 1);
          run_ref = live_runs[pick];
          live_runs.delete(pick);
          r.pool   = run_ref[OFFSET_W +: POOL_W];
          r.offset = run_ref[OFFSET_W-1:0];
        end else if ($urandom_range(0, 3) == 0) begin
          r.offset = OFFSET_W'($urandom_range(0, 131071));
        end else begin
          r.offset = OFFSET_W'($urandom_range(0, POOL_BYTES - 1));
        end
      end else if (kind < 97) begin
        r.command = CMD_USAGE;
      end else begin
        r.command = CMD_CLEAR;
      end
      req_backlog.push_back(r);
    end

    // let everything drain, then watch for stray responses
    while (req_backlog.size() > 0 || req_ch.valid) @(posedge clk);
    while (answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d alloc, %0d free, %0d usage and %0d clear requests over both pools",
             cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE], cmd_seen[CMD_USAGE],
             cmd_seen[CMD_CLEAR]);
    $display("answers: %0d ok, %0d no space, %0d out of range, %0d zero size; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_NOSPACE], status_seen[ST_RANGE],
             status_seen[ST_ZERO], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
